// ----- sv/assert_macros.svh -----
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

// ----- sv/tkips_pkg.sv -----
// Package with types and constants of the top-k inner product search.
`timescale 1ns / 1ps
`default_nettype none
package tkips_pkg;
	localparam int MAX_POINTS_DEF = 1024;
	localparam int MAX_FEATURES_DEF = 256;
	localparam int MAX_K_DEF = 64;
	localparam int SCORE_W = 40;
	localparam int ACC_W = 48;
	localparam int ELEM_W = 16;
	localparam logic OP_POINT = 1'b0;
	localparam logic OP_QUERY = 1'b1;
	localparam logic [1:0] REG_K_BEST = 2'd0;
	localparam logic [1:0] REG_POINT_COUNT = 2'd1;
	localparam logic [1:0] REG_FEATURE_COUNT = 2'd2;
	typedef enum logic [3:0] {
		ST_IDLE, ST_RD, ST_MAC, ST_SAT, ST_SCAN, ST_SCAN2, ST_SHIFT, ST_INS, ST_OUTRD,
		ST_OUTRD2, ST_OUT
	} state_t;
endpackage
`default_nettype wire

// ----- sv/top_k_inner_product_search.sv -----
// Top level of the top-k inner product search.
// Point writes and query writes go straight into their RAMs. A final query
// element starts a search: for each of point_count points, one shared 16x16
// multiplier accumulates feature_count products (one per cycle, read from the
// point and query RAMs), then a ranked list in a small RAM is updated by a
// scan for the insert position and a shift of the weaker entries, one entry a
// cycle, which together touch at most k entries. A point whose score does not
// beat the worst entry of a full list skips the scan and the shift. Each of
// the k results is read from the list in ST_OUTRD and ST_OUTRD2 and presented
// in ST_OUT, which holds until the receiver takes it. No stream input is taken
// while a search runs or its results are sent. There is no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module top_k_inner_product_search #(
	parameter int MAX_POINTS = tkips_pkg::MAX_POINTS_DEF,
	parameter int MAX_FEATURES = tkips_pkg::MAX_FEATURES_DEF,
	parameter int MAX_K = tkips_pkg::MAX_K_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [10:0] cfg_data,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// point_slot, feature_slot, element_value, zero pad
	input  wire logic [39:0] s_tdata,
	// opcode
	input  wire logic        s_tuser,
	// query_done
	input  wire logic        s_tlast,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// rank, best_point, score, zero pad
	output logic [63:0]      m_tdata,
	// final_result
	output logic             m_tlast
);
	import tkips_pkg::*;
	localparam int PW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int FW = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
	localparam int KW = (MAX_K > 1) ? $clog2(MAX_K) : 1;
	localparam int SW = $clog2(MAX_POINTS * MAX_FEATURES);

	state_t state_q, state_d;
	logic [6:0] k_best_q;
	logic [10:0] point_count_q;
	logic [8:0] feature_count_q;
	logic [6:0] k_eff;
	logic [16:0] np_eff;
	logic [12:0] nf_eff;

	logic [PW:0] pt_q;
	logic [FW:0] ft_q;
	logic [ACC_W-1:0] acc_q;
	logic signed [SCORE_W-1:0] s_q;
	logic [6:0] kept_q, pos_q, i_q;
	logic [6:0] r_q;

	logic op;
	logic [9:0] in_row;
	logic [7:0] in_col;
	logic [15:0] in_val;
	logic in_done;
	logic acc_in;

	assign op = s_tuser;
	assign in_row = s_tdata[9:0];
	assign in_col = s_tdata[17:10];
	assign in_val = s_tdata[33:18];
	assign in_done = s_tlast;
	assign s_tready = (state_q == ST_IDLE);
	assign acc_in = s_tvalid && s_tready;

	always_comb begin
		k_eff = (k_best_q == 7'd0) ? 7'd1 :
			((32'(k_best_q) > MAX_K) ? 7'(MAX_K) : k_best_q);
		np_eff = (point_count_q == 11'd0) ? 17'd1 :
			((32'(point_count_q) > MAX_POINTS) ? 17'(MAX_POINTS) : 17'(point_count_q));
		nf_eff = (feature_count_q == 9'd0) ? 13'd1 :
			((32'(feature_count_q) > MAX_FEATURES) ? 13'(MAX_FEATURES) : 13'(feature_count_q));
	end

	// Point and query memories.
	logic p_we, q_we;
	logic [SW-1:0] p_waddr, p_raddr;
	logic [15:0] p_rdata, q_rdata;
	logic [FW-1:0] q_raddr;
	assign p_we = acc_in && op == OP_POINT && 32'(in_row) < MAX_POINTS
		&& 32'(in_col) < MAX_FEATURES;
	assign q_we = acc_in && op == OP_QUERY && 32'(in_col) < MAX_FEATURES;
	assign p_waddr = SW'(32'(in_row) * MAX_FEATURES + 32'(in_col));
	assign p_raddr = SW'(32'(pt_q[PW-1:0]) * MAX_FEATURES + 32'(ft_q[FW-1:0]));
	assign q_raddr = ft_q[FW-1:0];

	tkips_ram #(.WIDTH(ELEM_W), .DEPTH(MAX_POINTS * MAX_FEATURES)) u_points (
		.clk(clk), .we(p_we), .waddr(p_waddr), .wdata(in_val),
		.raddr(p_raddr), .rdata(p_rdata)
	);
	tkips_ram #(.WIDTH(ELEM_W), .DEPTH(MAX_FEATURES)) u_query (
		.clk(clk), .we(q_we), .waddr(FW'(in_col)), .wdata(in_val),
		.raddr(q_raddr), .rdata(q_rdata)
	);

	// Ranked list memory holding score and point index.
	logic l_we;
	logic [KW-1:0] l_waddr, l_raddr;
	logic [SCORE_W+PW-1:0] l_wdata, l_rdata;
	tkips_ram #(.WIDTH(SCORE_W + PW), .DEPTH(MAX_K)) u_list (
		.clk(clk), .we(l_we), .waddr(l_waddr), .wdata(l_wdata),
		.raddr(l_raddr), .rdata(l_rdata)
	);
	logic signed [SCORE_W-1:0] l_score;
	assign l_score = l_rdata[SCORE_W-1:0];

	logic signed [31:0] prod;
	assign prod = $signed(p_rdata) * $signed(q_rdata);
	logic signed [ACC_W-1:0] acc_s;
	assign acc_s = $signed(acc_q);

	logic [6:0] kept_n;
	assign kept_n = (kept_q >= k_eff) ? k_eff - 7'd1 : kept_q;

	always_comb begin
		state_d = state_q;
		l_we = 1'b0;
		l_waddr = '0;
		l_wdata = '0;
		l_raddr = '0;
		case (state_q)
			ST_IDLE: begin
				if (acc_in && op == OP_QUERY && in_done) begin
					state_d = ST_RD;
				end
			end
			ST_RD: state_d = ST_MAC;
			ST_MAC: begin
				if (32'(ft_q) == 32'(nf_eff)) begin
					state_d = ST_SAT;
				end
			end
			ST_SAT: begin
				l_raddr = KW'(k_eff - 7'd1);
				state_d = ST_SCAN;
			end
			ST_SCAN: begin
				// Worst-entry check when the list is full; position scan otherwise or when the check passes.
				if (kept_q >= k_eff && !(s_q > l_score)) begin
					state_d = (32'(pt_q) == 32'(np_eff)) ? ST_OUTRD : ST_RD;
				end else begin
					l_raddr = '0;
					state_d = ST_SCAN2;
				end
			end
			ST_SCAN2: begin
				l_raddr = KW'(pos_q + 7'd1);
				if (pos_q >= kept_n || !(l_score >= s_q)) begin
					l_raddr = KW'(kept_n - 7'd1);
					state_d = (kept_n > pos_q) ? ST_SHIFT : ST_INS;
				end
			end
			ST_SHIFT: begin
				l_we = 1'b1;
				l_waddr = KW'(i_q);
				l_wdata = l_rdata;
				l_raddr = KW'(i_q - 7'd2);
				if (i_q - 7'd1 == pos_q) begin
					state_d = ST_INS;
				end
			end
			ST_INS: begin
				l_we = 1'b1;
				l_waddr = KW'(pos_q);
				l_wdata = {PW'(pt_q - 1'b1), s_q};
				state_d = (32'(pt_q) == 32'(np_eff)) ? ST_OUTRD : ST_RD;
			end
			ST_OUTRD: begin
				l_raddr = KW'(r_q);
				state_d = ST_OUTRD2;
			end
			ST_OUTRD2: begin
				l_raddr = KW'(r_q);
				state_d = ST_OUT;
			end
			ST_OUT: begin
				l_raddr = KW'(r_q);
				if (m_tready) begin
					state_d = (r_q + 7'd1 == k_eff) ? ST_IDLE : ST_OUTRD;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_best_q <= 7'd10;
			point_count_q <= 11'd1024;
			feature_count_q <= 9'd256;
			pt_q <= '0;
			ft_q <= '0;
			kept_q <= '0;
			pos_q <= '0;
			i_q <= '0;
			r_q <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_index)
					REG_K_BEST: k_best_q <= cfg_data[6:0];
					REG_POINT_COUNT: point_count_q <= cfg_data;
					REG_FEATURE_COUNT: feature_count_q <= cfg_data[8:0];
					default: ;
				endcase
			end
			case (state_q)
				ST_IDLE: begin
					pt_q <= '0;
					ft_q <= '0;
					kept_q <= '0;
					r_q <= '0;
				end
				ST_RD: ft_q <= ft_q + 1'b1;
				ST_MAC: ft_q <= ft_q + 1'b1;
				ST_SAT: begin
					ft_q <= '0;
					pt_q <= pt_q + 1'b1;
				end
				ST_SCAN: pos_q <= '0;
				ST_SCAN2: begin
					if (pos_q >= kept_n || !(l_score >= s_q)) begin
						i_q <= kept_n;
						kept_q <= kept_n;
					end else begin
						pos_q <= pos_q + 7'd1;
					end
				end
				ST_SHIFT: i_q <= i_q - 7'd1;
				ST_INS: kept_q <= kept_q + 7'd1;
				ST_OUT: if (m_tready) r_q <= r_q + 7'd1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_RD) begin
			acc_q <= '0;
		end else if (state_q == ST_MAC) begin
			acc_q <= ACC_W'(acc_s + ACC_W'(prod));
		end
		if (state_q == ST_SAT) begin
			if (acc_s > $signed(ACC_W'(SCORE_W'({1'b0, {(SCORE_W-1){1'b1}}})))) begin
				s_q <= {1'b0, {(SCORE_W-1){1'b1}}};
			end else if (acc_s < -$signed(ACC_W'({1'b1, {(SCORE_W-1){1'b0}}}))) begin
				s_q <= {1'b1, {(SCORE_W-1){1'b0}}};
			end else begin
				s_q <= acc_q[SCORE_W-1:0];
			end
		end
	end

	logic valid_rank;
	assign valid_rank = r_q < kept_q;
	assign m_tvalid = (state_q == ST_OUT);
	assign m_tlast = (r_q + 7'd1 == k_eff);
	assign m_tdata = {7'd0,
		valid_rank ? l_rdata[SCORE_W-1:0] : {SCORE_W{1'b0}},
		valid_rank ? 11'(l_rdata[SCORE_W+PW-1:SCORE_W]) : 11'h7FF,
		r_q[5:0]};

	`include "assert_macros.svh"
	`ASSERT_IMPL(a_kept_le_k, clk, arst_n, state_q != ST_IDLE, kept_q <= k_eff)
	`ASSERT_IMPL(a_busy, clk, arst_n, m_tvalid, !s_tready)
	`ASSERT_NEXT(a_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(r_q))
endmodule
`default_nettype wire

// ----- sv/tkips_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module tkips_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]              rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire
